// ===== sv/budgeted_deadline_task_scheduler_defines.svh =====
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Shared concurrent assertion forms.
// ----------------------------------------------------------------------------
`ifndef BUDGETED_DEADLINE_TASK_SCHEDULER_DEFINES_SVH
`define BUDGETED_DEADLINE_TASK_SCHEDULER_DEFINES_SVH

// implication checked on every edge outside reset
`define BDTS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BDTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/bdts_pkg.sv =====
// ----------------------------------------------------------------------------
// Scheduler package
// Types, codes and constants of the budgeted deadline task scheduler.
// ----------------------------------------------------------------------------
package bdts_pkg;
  localparam int QUEUE_DEPTH = 16;
  localparam int SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;

  localparam logic [2:0] FN_SUBMIT = 3'd0;
  localparam logic [2:0] FN_DISPATCH = 3'd1;
  localparam logic [2:0] FN_FINISH = 3'd2;
  localparam logic [2:0] FN_CANCEL = 3'd3;
  localparam logic [2:0] FN_DEADLINE = 3'd4;
  localparam logic [2:0] FN_STOP = 3'd5;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_REJECTED = 3'd1;
  localparam logic [2:0] ST_DISPATCHED = 3'd2;
  localparam logic [2:0] ST_NONE = 3'd3;
  localparam logic [2:0] ST_STOPPED = 3'd4;
  localparam logic [2:0] ST_ACK = 3'd5;

  localparam logic [2:0] REG_DUTY = 3'd0;
  localparam logic [2:0] REG_IBUDGET = 3'd1;
  localparam logic [2:0] REG_OBUDGET = 3'd2;
  localparam logic [2:0] REG_RESERVE = 3'd3;
  localparam logic [2:0] REG_WORKERS = 3'd4;

  localparam logic [1:0] E_FREE = 2'd0;
  localparam logic [1:0] E_QUEUED = 2'd1;
  localparam logic [1:0] E_ACTIVE = 2'd2;

  typedef struct packed {
    logic [2:0] func;
    logic [47:0] now_time;
    logic [1:0] kind;
    logic has_deadline;
    logic [47:0] deadline;
    logic [47:0] est_cost;
    logic [3:0] slot;
    logic [47:0] elapsed;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] task_slot;
    logic [31:0] task_sequence;
    logic [1:0] task_kind;
    logic task_cancelled;
    logic [47:0] wake_time;
    logic [4:0] queued_count;
    logic [4:0] active_count;
    logic [63:0] completed_count;
    logic [63:0] rejected_count;
  } rsp_t;

  typedef struct packed {
    logic [2:0] index;
    logic [47:0] data;
  } cfg_t;

  function automatic logic [1:0] kind_rank(input logic [1:0] k);
    case (k)
      2'd0: kind_rank = 2'd2;
      2'd1: kind_rank = 2'd1;
      2'd2: kind_rank = 2'd2;
      default: kind_rank = 2'd3;
    endcase
  endfunction

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add48 = s[48] ? M48 : s[47:0];
  endfunction
endpackage

// ===== sv/bdts_if.sv =====
// ----------------------------------------------------------------------------
// Scheduler channels
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface bdts_req_if;
  logic valid;
  logic ready;
  bdts_pkg::req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface bdts_rsp_if;
  logic valid;
  logic ready;
  bdts_pkg::rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface bdts_cfg_if;
  logic valid;
  logic ready;
  bdts_pkg::cfg_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== sv/bdts_better.sv =====
// ----------------------------------------------------------------------------
// Scheduler ordering compare
// Decides whether a candidate entry precedes the current pick.
// ----------------------------------------------------------------------------
module bdts_better (
  input  logic        a_hd,
  input  logic [47:0] a_dl,
  input  logic [1:0]  a_kind,
  input  logic [31:0] a_seq,
  input  logic        b_hd,
  input  logic [47:0] b_dl,
  input  logic [1:0]  b_kind,
  input  logic [31:0] b_seq,
  output logic        wins
);
  logic [1:0] ra, rb;
  always_comb begin
    ra = bdts_pkg::kind_rank(a_kind);
    rb = bdts_pkg::kind_rank(b_kind);
    if (a_hd && b_hd && a_dl != b_dl) wins = a_dl < b_dl;
    else if (a_hd != b_hd) wins = a_hd;
    else if (ra != rb) wins = ra < rb;
    else wins = a_seq < b_seq;
  end
endmodule

// ===== sv/budgeted_deadline_task_scheduler.sv =====
// Flow: each item passes through the prepare and done states before its result
// is shown; a dispatch on a nonempty table and the first stop also scan every
// table entry in between. One item at a time: no new item or register write is
// taken until the result has been accepted.
// Reset (rst, synchronous) frees every entry, restores register defaults and
// clears counters; entry payload fields are not reset.
// ----------------------------------------------------------------------------
// Budgeted deadline task scheduler
// Task table with admission control and budgeted earliest-deadline dispatch.
// ----------------------------------------------------------------------------
module budgeted_deadline_task_scheduler (
  input  logic clk,
  input  logic rst,
  bdts_cfg_if.sink    cfg,
  bdts_req_if.sink    req,
  bdts_rsp_if.source  rsp
);
  localparam int D = bdts_pkg::QUEUE_DEPTH;
  localparam int SW = bdts_pkg::SLOT_W;
  localparam int CW = bdts_pkg::CNT_W;

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_SCAN, S_DONE, S_OUT} state_t;
  state_t state;

  logic [47:0] win_len, interactive_budget, offline_budget, guard_time;
  logic [7:0] pool_size;

  logic [1:0] e_status [D];
  logic [1:0] e_kind [D];
  logic e_hd [D];
  logic [47:0] e_dl [D];
  logic [31:0] e_seq [D];
  logic [47:0] e_cost [D];
  logic e_canc [D];

  logic [31:0] next_sequence;
  logic gd_valid;
  logic [47:0] gd_time, window_start, i_used, o_used, i_held, o_held;
  logic [CW-1:0] running_count;
  logic [63:0] done_total, refused_total;
  logic stopping;

  bdts_pkg::req_t r;
  bdts_pkg::rsp_t o;
  logic [SW-1:0] idx;
  logic [SW-1:0] cur;
  logic [SW-1:0] pick;
  logic have_pick, pick_canc, close, have_free;
  logic [SW-1:0] free_slot;
  logic [CW-1:0] queued;

  assign cfg.ready = (state == S_IDLE);
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.data = o;
  assign cur = idx;

  always_comb begin
    queued = '0;
    have_free = 1'b0;
    free_slot = '0;
    for (int i = D - 1; i >= 0; i--) begin
      if (e_status[i] == bdts_pkg::E_QUEUED) queued = queued + CW'(1);
      if (e_status[i] == bdts_pkg::E_FREE) begin
        have_free = 1'b1;
        free_slot = SW'(i);
      end
    end
  end

  // eligibility of the scanned entry
  logic [47:0] lim, used, held, avail;
  logic elig, cand_ok, wins, cand_canc;
  always_comb begin
    lim = (e_kind[cur] == 2'd1) ? interactive_budget : offline_budget;
    used = (e_kind[cur] == 2'd1) ? i_used : o_used;
    held = (e_kind[cur] == 2'd1) ? i_held : o_held;
    avail = lim - used;
    if (stopping || e_kind[cur] == 2'd0) elig = 1'b1;
    else if (close) elig = 1'b0;
    else if (used >= lim) elig = 1'b0;
    else if (held > avail || e_cost[cur] > avail - held) elig = 1'b0;
    else elig = 1'b1;
    cand_canc = e_canc[cur];
    cand_ok = (e_status[cur] == bdts_pkg::E_QUEUED);
  end

  bdts_better u_better (
    .a_hd(e_hd[cur]), .a_dl(e_dl[cur]), .a_kind(e_kind[cur]), .a_seq(e_seq[cur]),
    .b_hd(e_hd[pick]), .b_dl(e_dl[pick]), .b_kind(e_kind[pick]), .b_seq(e_seq[pick]),
    .wins(wins)
  );

  logic [47:0] lim_s, cost_s, sum_rs;
  logic [48:0] sum_w;
  logic guest_close, sub_reject, scan_go;
  always_comb begin
    lim_s = (r.kind == 2'd1) ? interactive_budget : offline_budget;
    cost_s = (r.est_cost == '0) ? lim_s : r.est_cost;
    sum_w = {1'b0, r.now_time} + {1'b0, guard_time};
    sum_rs = '0;
    sum_rs = sum_w[47:0];
    guest_close = gd_valid && (sum_w[48] || gd_time <= sum_rs);
    sub_reject = stopping || pool_size == '0 || !have_free ||
                 (r.kind != 2'd0 && guest_close) ||
                 (r.kind != 2'd0 && (lim_s == '0 || cost_s > lim_s));
    scan_go = (r.func == bdts_pkg::FN_DISPATCH && queued != '0) ||
              (r.func == bdts_pkg::FN_STOP && !stopping);
  end

  // result fields known right after the item is taken
  bdts_pkg::rsp_t prep_rsp;
  always_comb begin
    prep_rsp = '0;
    prep_rsp.status = bdts_pkg::ST_ACK;
    if (r.func == bdts_pkg::FN_SUBMIT) begin
      if (sub_reject) begin
        prep_rsp.status = bdts_pkg::ST_REJECTED;
      end else begin
        prep_rsp.status = bdts_pkg::ST_ACCEPTED;
        prep_rsp.task_slot = 4'(free_slot);
        prep_rsp.task_sequence = next_sequence;
        prep_rsp.task_kind = r.kind;
      end
    end else if (r.func == bdts_pkg::FN_DISPATCH && queued == '0) begin
      prep_rsp.status = stopping ? bdts_pkg::ST_STOPPED : bdts_pkg::ST_NONE;
    end
  end

  // final result, counts as they stand after the item
  bdts_pkg::rsp_t done_rsp;
  always_comb begin
    done_rsp = o;
    done_rsp.queued_count = 5'(queued);
    done_rsp.active_count = 5'(running_count);
    done_rsp.completed_count = done_total;
    done_rsp.rejected_count = refused_total;
    if (r.func == bdts_pkg::FN_DISPATCH && queued != '0) begin
      if (!have_pick) begin
        done_rsp.status = bdts_pkg::ST_NONE;
        done_rsp.wake_time = bdts_pkg::sat_add48(window_start, win_len);
      end else begin
        done_rsp.status = bdts_pkg::ST_DISPATCHED;
        done_rsp.task_slot = 4'(pick);
        done_rsp.task_sequence = e_seq[pick];
        done_rsp.task_kind = e_kind[pick];
        done_rsp.task_cancelled = e_canc[pick];
        done_rsp.queued_count = 5'(queued) - 5'd1;
        done_rsp.active_count = 5'(running_count) + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      win_len <= 48'd10000000;
      interactive_budget <= 48'd2000000;
      offline_budget <= '0;
      guard_time <= '0;
      pool_size <= 8'd1;
      for (int i = 0; i < D; i++) e_status[i] <= bdts_pkg::E_FREE;
      next_sequence <= '0;
      gd_valid <= 1'b0;
      gd_time <= '0;
      window_start <= '0;
      i_used <= '0;
      o_used <= '0;
      i_held <= '0;
      o_held <= '0;
      running_count <= '0;
      done_total <= '0;
      refused_total <= '0;
      stopping <= 1'b0;
      idx <= '0;
      pick <= '0;
      have_pick <= 1'b0;
      pick_canc <= 1'b0;
      close <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg.valid) begin
            case (cfg.data.index)
              bdts_pkg::REG_DUTY: win_len <= cfg.data.data;
              bdts_pkg::REG_IBUDGET: interactive_budget <= cfg.data.data;
              bdts_pkg::REG_OBUDGET: offline_budget <= cfg.data.data;
              bdts_pkg::REG_RESERVE: guard_time <= cfg.data.data;
              bdts_pkg::REG_WORKERS: pool_size <= cfg.data.data[7:0];
              default: ;
            endcase
          end
          if (req.valid) begin
            r <= req.data;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          o <= prep_rsp;
          idx <= '0;
          have_pick <= 1'b0;
          pick_canc <= 1'b0;
          pick <= '0;
          close <= guest_close;
          state <= scan_go ? S_SCAN : S_DONE;
          case (r.func)
            bdts_pkg::FN_SUBMIT: begin
              if (sub_reject) begin
                refused_total <= refused_total + 64'd1;
              end else begin
                e_status[free_slot] <= bdts_pkg::E_QUEUED;
                e_kind[free_slot] <= r.kind;
                e_hd[free_slot] <= r.has_deadline;
                e_dl[free_slot] <= r.deadline;
                e_seq[free_slot] <= next_sequence;
                e_cost[free_slot] <= (r.kind == 2'd0) ? '0 : cost_s;
                e_canc[free_slot] <= 1'b0;
                next_sequence <= next_sequence + 32'd1;
              end
            end
            bdts_pkg::FN_DISPATCH: begin
              if (queued != '0 && r.now_time >= window_start &&
                  r.now_time - window_start >= win_len) begin
                window_start <= r.now_time;
                i_used <= '0;
                o_used <= '0;
              end
            end
            bdts_pkg::FN_FINISH: begin
              if (e_status[r.slot[SW-1:0]] == bdts_pkg::E_ACTIVE) begin
                if (e_kind[r.slot[SW-1:0]] == 2'd1) begin
                  i_held <= (i_held > e_cost[r.slot[SW-1:0]]) ?
                            i_held - e_cost[r.slot[SW-1:0]] : '0;
                  i_used <= bdts_pkg::sat_add48(i_used, r.elapsed);
                end else if (e_kind[r.slot[SW-1:0]] != 2'd0) begin
                  o_held <= (o_held > e_cost[r.slot[SW-1:0]]) ?
                            o_held - e_cost[r.slot[SW-1:0]] : '0;
                  o_used <= bdts_pkg::sat_add48(o_used, r.elapsed);
                end
                e_status[r.slot[SW-1:0]] <= bdts_pkg::E_FREE;
                if (running_count != '0) running_count <= running_count - CW'(1);
                done_total <= done_total + 64'd1;
              end
            end
            bdts_pkg::FN_CANCEL: begin
              if (e_status[r.slot[SW-1:0]] == bdts_pkg::E_QUEUED)
                e_canc[r.slot[SW-1:0]] <= 1'b1;
            end
            bdts_pkg::FN_DEADLINE: begin
              gd_valid <= r.has_deadline;
              gd_time <= r.has_deadline ? r.deadline : '0;
            end
            bdts_pkg::FN_STOP: begin
              if (!stopping) stopping <= 1'b1;
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          if (r.func == bdts_pkg::FN_STOP) begin
            if (cand_ok) e_canc[cur] <= 1'b1;
          end else if (cand_ok) begin
            if (cand_canc) begin
              if (!pick_canc || e_seq[cur] < e_seq[pick]) begin
                pick <= cur;
                have_pick <= 1'b1;
                pick_canc <= 1'b1;
              end
            end else if (!pick_canc && elig && (!have_pick || wins)) begin
              pick <= cur;
              have_pick <= 1'b1;
            end
          end
          idx <= idx + SW'(1);
          if (idx == SW'(D - 1)) state <= S_DONE;
        end
        S_DONE: begin
          if (r.func == bdts_pkg::FN_DISPATCH && queued != '0 && have_pick) begin
            e_status[pick] <= bdts_pkg::E_ACTIVE;
            if (e_kind[pick] == 2'd1) i_held <= bdts_pkg::sat_add48(i_held, e_cost[pick]);
            else if (e_kind[pick] != 2'd0)
              o_held <= bdts_pkg::sat_add48(o_held, e_cost[pick]);
            running_count <= running_count + CW'(1);
          end
          o <= done_rsp;
          state <= S_OUT;
        end
        S_OUT: begin
          if (rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/bdts_checker.sv =====
// ----------------------------------------------------------------------------
// Scheduler port checker
// Port-level properties of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "budgeted_deadline_task_scheduler_defines.svh"

module bdts_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic [2:0] status,
  input logic [4:0] queued_count,
  input logic [4:0] active_count
);
  `BDTS_ASSERT_IMP(a_no_ready_while_out, clk, rst, rsp_valid, !req_ready)
  `BDTS_ASSERT_NEXT(a_accept_busy, clk, rst, req_valid && req_ready, !req_ready)
  `BDTS_ASSERT_NEXT(a_rsp_held, clk, rst, rsp_valid && !rsp_ready, rsp_valid)
  `BDTS_ASSERT_IMP(a_counts_fit, clk, rst, rsp_valid,
    queued_count + active_count <= 5'd16)
  `BDTS_ASSERT_IMP(a_status_code, clk, rst, rsp_valid, status <= 3'd5)
endmodule

bind budgeted_deadline_task_scheduler bdts_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .status(rsp.data.status),
  .queued_count(rsp.data.queued_count), .active_count(rsp.data.active_count)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scheduler testbench
// Drives submit, dispatch, finish, cancel, deadline and stop requests into
// the task scheduler under random idling on both channels. A built-in model
// of the task table and duty-window budgets predicts each response, which
// is then checked field by field.
// ----------------------------------------------------------------------------
module testbench;
  localparam int LIMIT = 2000000;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int cycles = 0;
  int sent = 0;
  bit calm = 1'b0;
  logic [47:0] clock_ns = '0;
  logic [47:0] cost_max = 48'd3000000;

  bdts_cfg_if cfg();
  bdts_req_if req();
  bdts_rsp_if rsp();

  budgeted_deadline_task_scheduler DUT (
    .clk(clk), .rst(rst), .cfg(cfg.sink), .req(req.sink), .rsp(rsp.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  class sched_scoreboard;
    logic [1:0] state[bdts_pkg::QUEUE_DEPTH];
    logic [1:0] kind[bdts_pkg::QUEUE_DEPTH];
    bit has_dl[bdts_pkg::QUEUE_DEPTH];
    logic [47:0] dl[bdts_pkg::QUEUE_DEPTH];
    logic [31:0] seq[bdts_pkg::QUEUE_DEPTH];
    logic [47:0] cost[bdts_pkg::QUEUE_DEPTH];
    bit cancelled[bdts_pkg::QUEUE_DEPTH];
    logic [31:0] next_seq;
    bit guest_valid;
    logic [47:0] guest_time, win_start, int_used, off_used, int_held, off_held;
    logic [4:0] running;
    logic [63:0] done, refused;
    bit halted;
    logic [47:0] duty, int_budget, off_budget, reserve;
    logic [7:0] workers;
    bdts_pkg::rsp_t awaited[$];
    int errors;

    function new();
      for (int i = 0; i < bdts_pkg::QUEUE_DEPTH; i++) begin
        state[i] = bdts_pkg::E_FREE; kind[i] = '0; has_dl[i] = 0; dl[i] = '0;
        seq[i] = '0; cost[i] = '0; cancelled[i] = 0;
      end
      next_seq = '0; guest_valid = 0; guest_time = '0; win_start = '0;
      int_used = '0; off_used = '0; int_held = '0; off_held = '0;
      running = '0; done = '0; refused = '0; halted = 0; errors = 0;
      duty = 48'd10000000; int_budget = 48'd2000000; off_budget = '0;
      reserve = '0; workers = 8'd1;
    endfunction

    function void write_reg(bdts_pkg::cfg_t c);
      case (c.index)
        bdts_pkg::REG_DUTY: duty = c.data;
        bdts_pkg::REG_IBUDGET: int_budget = c.data;
        bdts_pkg::REG_OBUDGET: off_budget = c.data;
        bdts_pkg::REG_RESERVE: reserve = c.data;
        bdts_pkg::REG_WORKERS: workers = c.data[7:0];
        default: ;
      endcase
    endfunction

    function logic [47:0] clamp_sum(logic [47:0] a, logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? MAX48 : s[47:0];
    endfunction

    function bit guest_close(logic [47:0] now);
      return guest_valid && ({1'b0, guest_time} <= {1'b0, now} + {1'b0, reserve});
    endfunction

    function int rank(logic [1:0] k);
      return k == 2'd1 ? 1 : (k == 2'd3 ? 3 : 2);
    endfunction

    function bit runnable(int i, bit close);
      logic [47:0] lim, used, held, avail;
      if (halted || kind[i] == 2'd0) return 1;
      if (close) return 0;
      lim = kind[i] == 2'd1 ? int_budget : off_budget;
      used = kind[i] == 2'd1 ? int_used : off_used;
      held = kind[i] == 2'd1 ? int_held : off_held;
      if (used >= lim) return 0;
      avail = lim - used;
      return !(held > avail || cost[i] > avail - held);
    endfunction

    function bit wins(int a, int b);
      if (has_dl[a] && has_dl[b] && dl[a] != dl[b]) return dl[a] < dl[b];
      if (has_dl[a] != has_dl[b]) return has_dl[a];
      if (rank(kind[a]) != rank(kind[b])) return rank(kind[a]) < rank(kind[b]);
      return seq[a] < seq[b];
    endfunction

    function int count_in(logic [1:0] s);
      int n;
      n = 0;
      for (int i = 0; i < bdts_pkg::QUEUE_DEPTH; i++) if (state[i] == s) n++;
      return n;
    endfunction

    function void note(bdts_pkg::req_t r);
      bdts_pkg::rsp_t e;
      int pick;
      bit close;
      logic [47:0] c, lim;
      e = '0;
      e.status = bdts_pkg::ST_ACK;
      pick = bdts_pkg::QUEUE_DEPTH;
      case (r.func)
        bdts_pkg::FN_SUBMIT: begin
          for (int i = bdts_pkg::QUEUE_DEPTH - 1; i >= 0; i--)
            if (state[i] == bdts_pkg::E_FREE) pick = i;
          c = r.est_cost;
          lim = r.kind == 2'd1 ? int_budget : off_budget;
          if (r.kind == 2'd0) c = '0;
          else if (c == '0) c = lim;
          if (halted || workers == '0 || pick == bdts_pkg::QUEUE_DEPTH ||
              (r.kind != 2'd0 && guest_close(r.now_time)) ||
              (r.kind != 2'd0 && (lim == '0 || c > lim))) begin
            refused++;
            e.status = bdts_pkg::ST_REJECTED;
          end else begin
            state[pick] = bdts_pkg::E_QUEUED; kind[pick] = r.kind;
            has_dl[pick] = r.has_deadline;
            dl[pick] = r.deadline; seq[pick] = next_seq; cost[pick] = c;
            cancelled[pick] = 0;
            next_seq++;
            e.status = bdts_pkg::ST_ACCEPTED;
            e.task_slot = pick[3:0]; e.task_sequence = seq[pick]; e.task_kind = r.kind;
          end
        end
        bdts_pkg::FN_DISPATCH: begin
          if (count_in(bdts_pkg::E_QUEUED) == 0) begin
            e.status = halted ? bdts_pkg::ST_STOPPED : bdts_pkg::ST_NONE;
          end else begin
            if (r.now_time >= win_start && r.now_time - win_start >= duty) begin
              win_start = r.now_time; int_used = '0; off_used = '0;
            end
            close = guest_close(r.now_time);
            for (int i = 0; i < bdts_pkg::QUEUE_DEPTH; i++)
              if (state[i] == bdts_pkg::E_QUEUED && cancelled[i] &&
                  (pick == bdts_pkg::QUEUE_DEPTH || seq[i] < seq[pick])) pick = i;
            if (pick == bdts_pkg::QUEUE_DEPTH)
              for (int i = 0; i < bdts_pkg::QUEUE_DEPTH; i++)
                if (state[i] == bdts_pkg::E_QUEUED && runnable(i, close) &&
                    (pick == bdts_pkg::QUEUE_DEPTH || wins(i, pick))) pick = i;
            if (pick == bdts_pkg::QUEUE_DEPTH) begin
              e.status = bdts_pkg::ST_NONE;
              e.wake_time = clamp_sum(win_start, duty);
            end else begin
              state[pick] = bdts_pkg::E_ACTIVE;
              if (kind[pick] == 2'd1) int_held = clamp_sum(int_held, cost[pick]);
              else if (kind[pick] != 2'd0) off_held = clamp_sum(off_held, cost[pick]);
              running++;
              e.status = bdts_pkg::ST_DISPATCHED;
              e.task_slot = pick[3:0]; e.task_sequence = seq[pick];
              e.task_kind = kind[pick]; e.task_cancelled = cancelled[pick];
            end
          end
        end
        bdts_pkg::FN_FINISH: begin
          if (state[r.slot] == bdts_pkg::E_ACTIVE) begin
            c = cost[r.slot];
            if (kind[r.slot] == 2'd1) begin
              int_held = int_held > c ? int_held - c : '0;
              int_used = clamp_sum(int_used, r.elapsed);
            end else if (kind[r.slot] != 2'd0) begin
              off_held = off_held > c ? off_held - c : '0;
              off_used = clamp_sum(off_used, r.elapsed);
            end
            state[r.slot] = bdts_pkg::E_FREE;
            if (running != '0) running--;
            done++;
          end
        end
        bdts_pkg::FN_CANCEL: if (state[r.slot] == bdts_pkg::E_QUEUED) cancelled[r.slot] = 1;
        bdts_pkg::FN_DEADLINE: begin
          guest_valid = r.has_deadline;
          guest_time = r.has_deadline ? r.deadline : '0;
        end
        bdts_pkg::FN_STOP: begin
          if (!halted) begin
            halted = 1;
            for (int i = 0; i < bdts_pkg::QUEUE_DEPTH; i++)
              if (state[i] == bdts_pkg::E_QUEUED) cancelled[i] = 1;
          end
        end
        default: ;
      endcase
      e.queued_count = 5'(count_in(bdts_pkg::E_QUEUED));
      e.active_count = running;
      e.completed_count = done;
      e.rejected_count = refused;
      awaited.push_back(e);
    endfunction

    function void field(string n, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, n, e, a);
      end
    endfunction

    function void check(bdts_pkg::rsp_t a);
      bdts_pkg::rsp_t e;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected response, expected none, actual %h", $time, a);
        return;
      end
      e = awaited.pop_front();
      field("status", e.status, a.status);
      field("task_slot", e.task_slot, a.task_slot);
      field("task_sequence", e.task_sequence, a.task_sequence);
      field("task_kind", e.task_kind, a.task_kind);
      field("task_cancelled", e.task_cancelled, a.task_cancelled);
      field("wake_time", e.wake_time, a.wake_time);
      field("queued_count", e.queued_count, a.queued_count);
      field("active_count", e.active_count, a.active_count);
      field("completed_count", e.completed_count, a.completed_count);
      field("rejected_count", e.rejected_count, a.rejected_count);
    endfunction
  endclass

  sched_scoreboard sched = new();

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (!rst && rsp.valid && rsp.ready) sched.check(rsp.data);
    rsp.ready <= calm || ($urandom_range(99) >= 26);
  end

  function automatic logic [47:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  function automatic logic [47:0] clip(logic [47:0] v);
    return cost_max == MAX48 ? v : v % (cost_max + 48'd1);
  endfunction

  task automatic send(bdts_pkg::req_t r);
    if (!calm && $urandom_range(99) < 26) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    req.valid <= 1'b1;
    req.data <= r;
    do @(posedge clk); while (!req.ready);
    sched.note(r);
    sent++;
    calm = sent >= 400 && sent < 600;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] value);
    bdts_pkg::cfg_t c;
    c.index = idx;
    c.data = value;
    cfg.valid <= 1'b1;
    cfg.data <= c;
    do @(posedge clk); while (!cfg.ready);
    sched.write_reg(c);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    req.valid <= 1'b0;
    while (sched.awaited.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  function automatic bdts_pkg::req_t op(logic [2:0] f, logic [1:0] k, logic [47:0] c);
    bdts_pkg::req_t r;
    r = '0;
    r.func = f; r.kind = k; r.est_cost = c; r.now_time = clock_ns;
    return r;
  endfunction

  function automatic int pick_slot(logic [1:0] s);
    int q[$];
    for (int i = 0; i < bdts_pkg::QUEUE_DEPTH; i++) if (sched.state[i] == s) q.push_back(i);
    if (q.size() == 0 || $urandom_range(99) < 20) return $urandom_range(15);
    return q[$urandom_range(q.size() - 1)];
  endfunction

  function automatic bdts_pkg::req_t random_op(bit allow_stop);
    bdts_pkg::req_t r;
    int w;
    r.now_time = '0;
    w = $urandom_range(99);
    clock_ns = clock_ns + 48'($urandom_range(0, 300000));
    r.func = w < 35 ? bdts_pkg::FN_SUBMIT : w < 65 ? bdts_pkg::FN_DISPATCH :
             w < 85 ? bdts_pkg::FN_FINISH : w < 92 ? bdts_pkg::FN_CANCEL :
             w < 97 ? bdts_pkg::FN_DEADLINE : w < 99 && allow_stop ? bdts_pkg::FN_STOP :
             3'($urandom_range(6, 7));
    r.now_time = $urandom_range(99) < 3 ? rand48() : clock_ns;
    r.kind = 2'($urandom_range(3));
    r.has_deadline = 1'($urandom_range(1));
    r.deadline = $urandom_range(9) == 0 ? rand48() :
                 clock_ns + 48'($urandom_range(0, 2000000));
    w = $urandom_range(99);
    r.est_cost = w < 20 ? '0 : w < 25 ? rand48() : clip(48'($urandom_range(1, 1000000)));
    r.slot = 4'($urandom_range(15));
    if (r.func == bdts_pkg::FN_FINISH) r.slot = 4'(pick_slot(bdts_pkg::E_ACTIVE));
    if (r.func == bdts_pkg::FN_CANCEL) r.slot = 4'(pick_slot(bdts_pkg::E_QUEUED));
    r.elapsed = $urandom_range(99) < 5 ? rand48() : clip(48'($urandom_range(0, 2000000)));
    return r;
  endfunction

  task automatic run_random(int n, bit allow_stop);
    repeat (n) send(random_op(allow_stop));
  endtask

  initial begin
    bdts_pkg::req_t r;
    req.valid = 1'b0; req.data = '0;
    cfg.valid = 1'b0; cfg.data = '0;
    rsp.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, register defaults
    send(op(bdts_pkg::FN_DISPATCH, 2'd0, '0));
    r = op(bdts_pkg::FN_SUBMIT, 2'd0, MAX48); r.has_deadline = 1; r.deadline = MAX48; send(r);
    send(op(bdts_pkg::FN_SUBMIT, 2'd1, '0));
    send(op(bdts_pkg::FN_SUBMIT, 2'd1, 48'd2000001));
    send(op(bdts_pkg::FN_SUBMIT, 2'd1, MAX48));
    send(op(bdts_pkg::FN_SUBMIT, 2'd2, 48'd5));
    r = op(bdts_pkg::FN_SUBMIT, 2'd3, '0); r.has_deadline = 1; send(r);
    clock_ns = 48'd100;
    r = op(bdts_pkg::FN_DEADLINE, 2'd0, '0); r.has_deadline = 1; r.deadline = 48'd100;
    send(r);
    send(op(bdts_pkg::FN_SUBMIT, 2'd1, 48'd1));
    send(op(bdts_pkg::FN_DISPATCH, 2'd0, '0));
    send(op(bdts_pkg::FN_DEADLINE, 2'd0, '0));
    clock_ns = 48'd12000000;
    send(op(bdts_pkg::FN_DISPATCH, 2'd0, '0));
    r = op(bdts_pkg::FN_FINISH, 2'd0, '0); r.slot = 4'd1; r.elapsed = MAX48; send(r);
    send(op(bdts_pkg::FN_SUBMIT, 2'd1, 48'd1));
    send(op(bdts_pkg::FN_DISPATCH, 2'd0, '0));
    r = op(bdts_pkg::FN_CANCEL, 2'd0, '0); r.slot = 4'd1; send(r);
    send(op(bdts_pkg::FN_DISPATCH, 2'd0, '0));
    r = op(bdts_pkg::FN_FINISH, 2'd0, '0); r.slot = 4'd0; send(r);
    r = op(bdts_pkg::FN_FINISH, 2'd0, '0); r.slot = 4'd15; send(r);
    r = op(bdts_pkg::FN_CANCEL, 2'd0, '0); r.slot = 4'd9; send(r);
    send(op(3'd6, 2'd0, '0));
    send(op(3'd7, 2'd0, '0));
    settle();

    write_reg(bdts_pkg::REG_OBUDGET, 48'd3000000);
    write_reg(bdts_pkg::REG_RESERVE, 48'd50000);
    write_reg(bdts_pkg::REG_WORKERS, 48'd4);
    run_random(300, 0);
    settle();

    write_reg(bdts_pkg::REG_DUTY, 48'd1);
    write_reg(bdts_pkg::REG_IBUDGET, 48'd1);
    write_reg(bdts_pkg::REG_OBUDGET, 48'd1);
    write_reg(bdts_pkg::REG_RESERVE, '0);
    cost_max = 48'd1;
    run_random(200, 0);
    settle();

    write_reg(bdts_pkg::REG_DUTY, MAX48);
    write_reg(bdts_pkg::REG_IBUDGET, MAX48);
    write_reg(bdts_pkg::REG_OBUDGET, MAX48);
    write_reg(bdts_pkg::REG_RESERVE, MAX48);
    write_reg(bdts_pkg::REG_WORKERS, 48'd255);
    cost_max = MAX48;
    run_random(200, 0);
    settle();

    write_reg(bdts_pkg::REG_RESERVE, 48'd1000);
    write_reg(bdts_pkg::REG_DUTY, 48'd700000);
    write_reg(bdts_pkg::REG_IBUDGET, 48'd900000);
    write_reg(bdts_pkg::REG_OBUDGET, 48'd400000);
    cost_max = 48'd600000;
    run_random(300, 0);
    settle();

    write_reg(bdts_pkg::REG_WORKERS, '0);
    run_random(60, 0);
    settle();

    write_reg(bdts_pkg::REG_WORKERS, 48'd2);
    run_random(120, 1);
    send(op(bdts_pkg::FN_STOP, 2'd0, '0));
    send(op(bdts_pkg::FN_STOP, 2'd0, '0));
    run_random(60, 0);
    repeat (18) send(op(bdts_pkg::FN_DISPATCH, 2'd0, '0));
    send(op(bdts_pkg::FN_SUBMIT, 2'd0, '0));
    settle();

    if (sched.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/bdts_pkg.sv
sv/bdts_if.sv
sv/bdts_better.sv
sv/budgeted_deadline_task_scheduler.sv
sv/bdts_checker.sv
sim/testbench.sv
